@@ sv/wsd_pkg.sv @@
// Shared types for the WebSocket frame deframer: parse phases and the result record.
package wsd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    localparam logic       KIND_HEADER  = 1'b0;
    localparam logic       KIND_PAYLOAD = 1'b1;
    localparam logic [6:0] LEN_EXT16    = 7'd126;
    localparam logic [6:0] LEN_EXT64    = 7'd127;
    localparam logic [2:0] EXT16_COUNT  = 3'd1;
    localparam logic [2:0] EXT64_COUNT  = 3'd7;
    localparam logic [1:0] KEY_LAST_IDX = 2'd3;

    typedef struct packed {
        logic        kind;
        logic        fin;
        logic [2:0]  rsv_bits;
        logic [3:0]  opcode;
        logic        masked;
        logic [63:0] payload_length;
        logic [7:0]  data_byte;
        logic        last;
    } result_t;

endpackage

@@ sv/websocket_frame_deframer_core.sv @@
// WebSocket receive deframer: one stream byte in per item, header and payload results out.
//
// Takes one received byte per clock cycle when the result side keeps up. Each
// byte updates the parse state in the cycle it is accepted; a result (one per
// frame header, then one per payload byte, unmasked) appears in the output
// register on the next cycle. Header bytes other than the final one produce no
// result. s_ready drops only while a result sits in the output register and
// m_ready is low, so throughput is one item per cycle unless the output stalls,
// set by the single parse-state register update. Reserved bits, opcodes and
// length encodings are passed through unchecked; fragment reassembly is not done here.
module websocket_frame_deframer_core import wsd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic        m_fin,
    output logic [2:0]  m_rsv_bits,
    output logic [3:0]  m_opcode,
    output logic        m_masked,
    output logic [63:0] m_payload_length,
    output logic [7:0]  m_data_byte,
    output logic        m_last
);

    logic    in_fire;
    logic    res_valid;
    result_t res;
    logic    m_valid_reg;
    result_t out_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_fire = s_valid && s_ready;

    wsd_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .rx_byte   (s_rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire) begin
            m_valid_reg <= res_valid;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // hold payload until a new result is loaded
    always_ff @(posedge aclk) begin
        if (in_fire && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = out_reg.kind;
    assign m_fin            = out_reg.fin;
    assign m_rsv_bits       = out_reg.rsv_bits;
    assign m_opcode         = out_reg.opcode;
    assign m_masked         = out_reg.masked;
    assign m_payload_length = out_reg.payload_length;
    assign m_data_byte      = out_reg.data_byte;
    assign m_last           = out_reg.last;

endmodule

@@ sv/wsd_parse.sv @@
// Frame parse state and the per-byte next-state and result logic.
module wsd_parse import wsd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    output result_t    res
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  ext_count_reg, ext_count_next;
    logic [63:0] length_accum_reg, length_accum_next;
    logic [31:0] mask_key_reg, mask_key_next;
    logic [1:0]  mask_index_reg, mask_index_next;
    logic [63:0] bytes_remaining_reg, bytes_remaining_next;
    logic [7:0]  first_byte_reg, first_byte_next;
    logic        mask_flag_reg, mask_flag_next;

    logic        finish;
    logic        emit_data;
    logic        data_last;
    logic [7:0]  key_byte;
    logic [7:0]  data_val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_HDR0;
            ext_count_reg       <= '0;
            length_accum_reg    <= '0;
            mask_key_reg        <= '0;
            mask_index_reg      <= '0;
            bytes_remaining_reg <= '0;
            first_byte_reg      <= '0;
            mask_flag_reg       <= 1'b0;
        end else if (in_fire) begin
            phase_reg           <= phase_next;
            ext_count_reg       <= ext_count_next;
            length_accum_reg    <= length_accum_next;
            mask_key_reg        <= mask_key_next;
            mask_index_reg      <= mask_index_next;
            bytes_remaining_reg <= bytes_remaining_next;
            first_byte_reg      <= first_byte_next;
            mask_flag_reg       <= mask_flag_next;
        end
    end

    // key bytes are stored first byte most significant
    always_comb begin
        case (mask_index_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
    end

    assign data_val  = mask_flag_reg ? (rx_byte ^ key_byte) : rx_byte;
    assign data_last = (bytes_remaining_reg == 64'd1);

    always_comb begin
        phase_next           = phase_reg;
        ext_count_next       = ext_count_reg;
        length_accum_next    = length_accum_reg;
        mask_key_next        = mask_key_reg;
        mask_index_next      = mask_index_reg;
        bytes_remaining_next = bytes_remaining_reg;
        first_byte_next      = first_byte_reg;
        mask_flag_next       = mask_flag_reg;
        finish               = 1'b0;
        emit_data            = 1'b0;

        case (phase_reg)
            PH_HDR1: begin
                mask_flag_next  = rx_byte[7];
                mask_key_next   = '0;
                mask_index_next = '0;
                if (rx_byte[6:0] == LEN_EXT16 || rx_byte[6:0] == LEN_EXT64) begin
                    length_accum_next = '0;
                    ext_count_next    = (rx_byte[6:0] == LEN_EXT16) ? EXT16_COUNT
                                                                    : EXT64_COUNT;
                    phase_next        = PH_EXT;
                end else begin
                    length_accum_next = {57'd0, rx_byte[6:0]};
                    if (rx_byte[7]) begin
                        phase_next = PH_KEY;
                    end else begin
                        finish = 1'b1;
                    end
                end
            end
            PH_EXT: begin
                length_accum_next = {length_accum_reg[55:0], rx_byte};
                if (ext_count_reg != 3'd0) begin
                    ext_count_next = ext_count_reg - 3'd1;
                end else if (mask_flag_reg) begin
                    phase_next = PH_KEY;
                end else begin
                    finish = 1'b1;
                end
            end
            PH_KEY: begin
                mask_key_next = {mask_key_reg[23:0], rx_byte};
                if (mask_index_reg != KEY_LAST_IDX) begin
                    mask_index_next = mask_index_reg + 2'd1;
                end else begin
                    finish = 1'b1;
                end
            end
            PH_DATA: begin
                emit_data            = 1'b1;
                mask_index_next      = mask_index_reg + 2'd1;
                bytes_remaining_next = bytes_remaining_reg - 64'd1;
                if (data_last) begin
                    phase_next = PH_HDR0;
                end
            end
            default: begin
                first_byte_next = rx_byte;
                phase_next      = PH_HDR1;
            end
        endcase

        // header complete: load the payload count and restart the key index
        if (finish) begin
            bytes_remaining_next = length_accum_next;
            mask_index_next      = '0;
            phase_next           = (length_accum_next == 64'd0) ? PH_HDR0 : PH_DATA;
        end
    end

    assign res_valid          = finish || emit_data;
    assign res.kind           = emit_data ? KIND_PAYLOAD : KIND_HEADER;
    assign res.fin            = first_byte_next[7];
    assign res.rsv_bits       = first_byte_next[6:4];
    assign res.opcode         = first_byte_next[3:0];
    assign res.masked         = mask_flag_next;
    assign res.payload_length = length_accum_next;
    assign res.data_byte      = emit_data ? data_val : 8'd0;
    assign res.last           = emit_data ? data_last : (length_accum_next == 64'd0);

endmodule

@@ sv/wsd_checker.sv @@
// Port-level checks for the deframer and their binding to the top level.
module wsd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_kind,
    input logic        m_fin,
    input logic [2:0]  m_rsv_bits,
    input logic [3:0]  m_opcode,
    input logic        m_masked,
    input logic [63:0] m_payload_length,
    input logic [7:0]  m_data_byte,
    input logic        m_last
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_byte) && $stable(m_kind)
                                && $stable(m_last) && $stable(m_payload_length)
                                && $stable(m_fin) && $stable(m_rsv_bits)
                                && $stable(m_opcode) && $stable(m_masked))
        else $error("result changed while stalled");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output register");

    a_header_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_kind |-> m_data_byte == 8'd0)
        else $error("header result carries nonzero data byte");

    a_header_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_kind |-> m_last == (m_payload_length == 64'd0))
        else $error("header last flag disagrees with payload length");

    a_payload_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind |-> m_payload_length != 64'd0)
        else $error("payload byte reported for an empty frame");

endmodule

bind websocket_frame_deframer_core wsd_checker u_wsd_checker (.*);
